FILE: hdl/linear_probe_id_table_assert.svh
// ----------------------------------------------------------------------------
// linear_probe_id_table assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_ID_TABLE_ASSERT_SVH
`define LINEAR_PROBE_ID_TABLE_ASSERT_SVH

// same-cycle implication
`define LPIT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("linear_probe_id_table check failed");

// next-cycle implication
`define LPIT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("linear_probe_id_table check failed");

`endif

FILE: hdl/lpit_pkg.sv
// ----------------------------------------------------------------------------
// lpit_pkg
// Shared constants for the linear-probing ID table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpit_pkg;

    localparam int TABLE_SIZE_DEF = 127;
    localparam int KEY_W          = 32;
    localparam int MOD_STEP       = 8;     // key bits reduced per cycle

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_HOME_ZERO = 2'd3;

endpackage

`default_nettype wire

FILE: hdl/lpit_mod.sv
// ----------------------------------------------------------------------------
// lpit_mod
// Iterative remainder of a 32-bit magnitude by the table size, MOD_STEP
// bits per cycle, restoring compare and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module lpit_mod #(
    parameter int TABLE_SIZE = lpit_pkg::TABLE_SIZE_DEF,
    parameter int SLOT_W     = $clog2(TABLE_SIZE)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [lpit_pkg::KEY_W-1:0] mag,
    output logic                           done,
    output logic [SLOT_W-1:0]              rem
);

    localparam int KW     = lpit_pkg::KEY_W;
    localparam int STEP   = lpit_pkg::MOD_STEP;
    localparam int NCYC   = KW / STEP;
    localparam int CNT_W  = (NCYC > 1) ? $clog2(NCYC) : 1;
    localparam logic [SLOT_W:0]   MODV = (SLOT_W + 1)'(TABLE_SIZE);
    localparam logic [CNT_W-1:0]  LAST = CNT_W'(NCYC - 1);

    logic [KW-1:0]     sh_reg;
    logic [SLOT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;

    always_comb
    begin
        logic [SLOT_W:0]   t;
        logic [SLOT_W-1:0] r;
        r = r_reg;
        for (int i = 0; i < STEP; i++)
        begin
            t = {r, sh_reg[KW-1-i]};
            if (t >= MODV)
            begin
                t = t - MODV;
            end
            r = t[SLOT_W-1:0];
        end
        r_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg <= mag;
            r_reg  <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg <= {sh_reg[KW-STEP-1:0], STEP'(0)};
            r_reg  <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

`default_nettype wire

FILE: hdl/lpit_mem.sv
// ----------------------------------------------------------------------------
// lpit_mem
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpit_mem #(
    parameter int DEPTH = lpit_pkg::TABLE_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = lpit_pkg::KEY_W + 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic [DW-1:0]      rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/linear_probe_id_table.sv
// ----------------------------------------------------------------------------
// linear_probe_id_table
// Open-addressing key to slot table with linear probing, one slot store.
// ----------------------------------------------------------------------------
//  channel | signals                          | dir
//  --------+----------------------------------+-----
//  in      | in_valid in_stall opcode key slot| in
//  out     | out_valid out_stall result_slot  | out
//          | status                           |
//
//  Find/insert: the home-slot remainder is reduced 8 key bits at a time, the
//  first read is issued, slots are probed in turn until a hit or until every
//  slot has been probed, and the result is handed off. A home slot of zero
//  ends the item after the remainder; free and unknown opcodes go straight
//  to the hand-off. After reset a clearing pass writes every slot with
//  in_stall high. in_stall is high whenever an item is in progress; a result
//  waiting on out_stall does not block the next input transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_id_table #(
    parameter int TABLE_SIZE = lpit_pkg::TABLE_SIZE_DEF,
    parameter int SLOT_W     = $clog2(TABLE_SIZE)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 opcode,
    input  wire logic signed [lpit_pkg::KEY_W-1:0] key,
    input  wire logic [SLOT_W-1:0]          slot,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [SLOT_W-1:0]               result_slot,
    output logic [1:0]                      status
);

`include "linear_probe_id_table_assert.svh"

    localparam int KW = lpit_pkg::KEY_W;
    localparam int DW = KW + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]        state_reg;
    logic [SLOT_W-1:0] clr_pos_reg;
    logic [1:0]        op_reg;
    logic [KW-1:0]     key_reg;
    logic [SLOT_W-1:0] issue_pos_reg, chk_pos_reg, count_reg;
    logic              chk_vld_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [1:0]        res_status_reg;
    logic              out_valid_reg;
    logic [SLOT_W-1:0] result_slot_reg;
    logic [1:0]        status_reg;

    logic              in_xfer;
    logic [KW-1:0]     key_u, mag;
    logic              mod_done;
    logic [SLOT_W-1:0] mod_rem;
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] mem_waddr;
    logic [DW-1:0]     mem_wdata, mem_rdata;
    logic              slot_used, key_eq, hit, probe_last, free_ok;
    logic [SLOT_W-1:0] next_pos;
    logic              out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    assign key_u = KW'(key);
    assign mag   = key_u[KW-1] ? (KW'(0) - key_u) : key_u;

    assign free_ok = (opcode == lpit_pkg::OP_FREE) && (slot <= LAST_SLOT);

    assign slot_used  = mem_rdata[KW];
    assign key_eq     = (mem_rdata[KW-1:0] == key_reg);
    assign hit        = (op_reg == lpit_pkg::OP_FIND) ? (slot_used && key_eq) : !slot_used;
    assign probe_last = (count_reg == LAST_SLOT);
    assign next_pos   = (issue_pos_reg == LAST_SLOT) ? '0 : issue_pos_reg + 1'b1;
    assign out_free   = !out_valid_reg || !out_stall;

    lpit_mod #(
        .TABLE_SIZE(TABLE_SIZE),
        .SLOT_W    (SLOT_W)
    ) u_mod (
        .clk  (clk),
        .rst_n(rst_n),
        .start(in_xfer && (opcode == lpit_pkg::OP_FIND || opcode == lpit_pkg::OP_INSERT)),
        .mag  (mag),
        .done (mod_done),
        .rem  (mod_rem)
    );

    lpit_mem #(
        .DEPTH(TABLE_SIZE),
        .AW   (SLOT_W),
        .DW   (DW)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(issue_pos_reg),
        .rdata(mem_rdata)
    );

    assign mem_re = (state_reg == S_PROBE);

    // word layout: {used, key}
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_pos_reg;
        mem_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                mem_we    = in_xfer && free_ok;
                mem_waddr = slot;
            end
            S_PROBE:
            begin
                mem_we    = chk_vld_reg && hit && (op_reg == lpit_pkg::OP_INSERT);
                mem_waddr = chk_pos_reg;
                mem_wdata = {1'b1, key_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_pos_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // hand-off below reloads the register in the same cycle
            if (out_valid_reg && !out_stall && (state_reg != S_RESP))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_pos_reg <= clr_pos_reg + 1'b1;
                    if (clr_pos_reg == LAST_SLOT)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (opcode == lpit_pkg::OP_FIND || opcode == lpit_pkg::OP_INSERT)
                        begin
                            state_reg <= S_MOD;
                        end
                        else
                        begin
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_MOD:
                begin
                    chk_vld_reg <= 1'b0;
                    count_reg   <= '0;
                    if (mod_done)
                    begin
                        state_reg <= (mod_rem == '0) ? S_RESP : S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (chk_vld_reg && (hit || probe_last))
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b1;
                        if (chk_vld_reg)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= opcode;
            key_reg <= key_u;
            if (free_ok)
            begin
                res_slot_reg   <= slot;
                res_status_reg <= lpit_pkg::ST_OK;
            end
            else
            begin
                res_slot_reg   <= '0;
                res_status_reg <= lpit_pkg::ST_NOT_FOUND;
            end
        end
        if (state_reg == S_MOD && mod_done)
        begin
            issue_pos_reg  <= mod_rem;
            res_slot_reg   <= '0;
            res_status_reg <= lpit_pkg::ST_HOME_ZERO;
        end
        if (state_reg == S_PROBE)
        begin
            issue_pos_reg <= next_pos;
            chk_pos_reg   <= issue_pos_reg;
            if (chk_vld_reg && hit)
            begin
                res_slot_reg   <= chk_pos_reg;
                res_status_reg <= lpit_pkg::ST_OK;
            end
            else if (chk_vld_reg && probe_last)
            begin
                res_slot_reg   <= '0;
                res_status_reg <= (op_reg == lpit_pkg::OP_FIND) ? lpit_pkg::ST_NOT_FOUND
                                                                : lpit_pkg::ST_FULL;
            end
        end
        if (state_reg == S_RESP && out_free)
        begin
            result_slot_reg <= res_slot_reg;
            status_reg      <= res_status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_slot = result_slot_reg;
    assign status      = status_reg;

    `LPIT_ASSERT_IMP(a_err_slot_zero, out_valid && status != lpit_pkg::ST_OK, result_slot == '0)
    `LPIT_ASSERT_IMP(a_ok_slot_range, out_valid && status == lpit_pkg::ST_OK, result_slot <= LAST_SLOT)
    `LPIT_ASSERT_IMP(a_mod_done_state, mod_done, state_reg == S_MOD)
    `LPIT_ASSERT_IMP(a_probe_write_ins, state_reg == S_PROBE && mem_we, op_reg == lpit_pkg::OP_INSERT)
    `LPIT_ASSERT_NXT(a_resp_after_hit, state_reg == S_PROBE && chk_vld_reg && hit, state_reg == S_RESP)

endmodule

`default_nettype wire
